// ----- src/sws_pkg.sv -----
`default_nettype none
package sws_pkg;

    localparam int PHASE_BITS    = 24;
    localparam int PATTERN_STEPS = 64;
    localparam int SAMPLE_RATE   = 44100;

    localparam int STEP_BITS = $clog2(PATTERN_STEPS);
    localparam int INC_BITS  = 20;
    localparam int NOTE_CNT  = 28;
    localparam int NOTE_BITS = 5;
    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = 2;
    localparam int CNT_BITS  = 14;
    localparam int LEFT_BITS = 15;
    localparam int ENV_BITS  = 16;
    localparam int PROD_BITS = 49;

    localparam logic [15:0] ENV_ONE = 16'd32768;

    localparam logic [2:0] MODE_BOSS     = 3'd3;
    localparam logic [2:0] MODE_GAMEOVER = 3'd5;
    localparam logic [2:0] MODE_DEFAULT  = 3'd7;
    localparam logic [2:0] PAT_GAMEPLAY  = 3'd2;

    localparam longint INC_DEN = longint'(SAMPLE_RATE) * 100;

    typedef struct packed {
        logic [2:0] mode;
        logic [2:0] pat;
        logic [4:0] trig;
        logic       cancel_boom;
    } item_t;

    typedef struct packed {
        logic       busy;
        logic [3:0] st;
    } sts_t;

    function automatic logic [INC_BITS-1:0] inc_of(input longint centi_hz);
        longint v;
        v = ((centi_hz << PHASE_BITS) + INC_DEN / 2) / INC_DEN;
        return v[INC_BITS-1:0];
    endfunction

    // note frequencies in hundredths of a Hz
    localparam longint NOTE_FREQ [NOTE_CNT] = '{
        0, 13081, 17461, 14683, 16481, 19600, 22000, 65925, 62225, 58733,
        52325, 49388, 44000, 39200, 34923, 32963, 12347, 11000, 29366, 26163,
        24694, 41530, 46616, 8731, 9250, 7778, 23308, 31113
    };

    localparam logic [INC_BITS-1:0] NOTE_INC [NOTE_CNT] = '{
        inc_of(NOTE_FREQ[0]),  inc_of(NOTE_FREQ[1]),  inc_of(NOTE_FREQ[2]),
        inc_of(NOTE_FREQ[3]),  inc_of(NOTE_FREQ[4]),  inc_of(NOTE_FREQ[5]),
        inc_of(NOTE_FREQ[6]),  inc_of(NOTE_FREQ[7]),  inc_of(NOTE_FREQ[8]),
        inc_of(NOTE_FREQ[9]),  inc_of(NOTE_FREQ[10]), inc_of(NOTE_FREQ[11]),
        inc_of(NOTE_FREQ[12]), inc_of(NOTE_FREQ[13]), inc_of(NOTE_FREQ[14]),
        inc_of(NOTE_FREQ[15]), inc_of(NOTE_FREQ[16]), inc_of(NOTE_FREQ[17]),
        inc_of(NOTE_FREQ[18]), inc_of(NOTE_FREQ[19]), inc_of(NOTE_FREQ[20]),
        inc_of(NOTE_FREQ[21]), inc_of(NOTE_FREQ[22]), inc_of(NOTE_FREQ[23]),
        inc_of(NOTE_FREQ[24]), inc_of(NOTE_FREQ[25]), inc_of(NOTE_FREQ[26]),
        inc_of(NOTE_FREQ[27])
    };

    // note codes per pattern, voice and step (boss harmony repeats every 8 steps)
    localparam logic [NOTE_BITS-1:0] PAT_TAB [7][3][16] = '{
        '{ '{16{5'd0}}, '{16{5'd0}}, '{16{5'd0}} },
        '{ '{16{5'd0}}, '{16{5'd0}}, '{16{5'd0}} },
        '{ '{16{5'd0}},
           '{5'd1,5'd0,5'd0,5'd0,5'd2,5'd0,5'd0,5'd0,5'd3,5'd0,5'd0,5'd0,5'd1,5'd0,5'd0,5'd0},
           '{16{5'd0}} },
        '{ '{5'd14,5'd0,5'd14,5'd21,5'd22,5'd0,5'd22,5'd10,
             5'd14,5'd0,5'd14,5'd21,5'd0,5'd0,5'd0,5'd0},
           '{5'd23,5'd23,5'd0,5'd23,5'd24,5'd24,5'd0,5'd24,
             5'd25,5'd25,5'd0,5'd25,5'd23,5'd23,5'd24,5'd0},
           '{5'd2,5'd0,5'd26,5'd0,5'd19,5'd0,5'd27,5'd0,
             5'd2,5'd0,5'd26,5'd0,5'd19,5'd0,5'd27,5'd0} },
        '{ '{16{5'd0}},
           '{5'd4,5'd0,5'd5,5'd0,5'd6,5'd0,5'd5,5'd0,5'd4,5'd0,5'd5,5'd0,5'd6,5'd0,5'd5,5'd0},
           '{16{5'd0}} },
        '{ '{5'd7,5'd8,5'd9,5'd10,5'd11,5'd12,5'd13,5'd14,
             5'd15,5'd0,5'd0,5'd0,5'd0,5'd0,5'd0,5'd0},
           '{5'd4,5'd0,5'd3,5'd0,5'd1,5'd0,5'd16,5'd0,
             5'd17,5'd0,5'd0,5'd0,5'd0,5'd0,5'd0,5'd0},
           '{5'd15,5'd0,5'd18,5'd0,5'd19,5'd0,5'd20,5'd0,
             5'd6,5'd0,5'd0,5'd0,5'd0,5'd0,5'd0,5'd0} },
        '{ '{5'd10,5'd0,5'd0,5'd0,5'd10,5'd0,5'd0,5'd0,5'd7,5'd0,5'd0,5'd0,5'd7,5'd0,5'd0,5'd0},
           '{5'd1,5'd0,5'd0,5'd0,5'd1,5'd0,5'd0,5'd0,5'd3,5'd0,5'd0,5'd0,5'd3,5'd0,5'd0,5'd0},
           '{16{5'd0}} }
    };

    // samples per sequencer step (sixteenth notes)
    localparam logic [CNT_BITS-1:0] SPS [7] = '{
        CNT_BITS'(SAMPLE_RATE * 60 / (118 * 4)), CNT_BITS'(SAMPLE_RATE * 60 / (120 * 4)),
        CNT_BITS'(SAMPLE_RATE * 60 / (142 * 4)), CNT_BITS'(SAMPLE_RATE * 60 / (128 * 4)),
        CNT_BITS'(SAMPLE_RATE * 60 / (124 * 4)), CNT_BITS'(SAMPLE_RATE * 60 / (88 * 4)),
        CNT_BITS'(SAMPLE_RATE * 60 / (60 * 4))
    };

    // voice weight times pattern gain
    localparam logic signed [31:0] MUS_WG [7][3] = '{
        '{32'sd3277 * 5898, 32'sd6554 * 5898, 32'sd3277 * 5898},
        '{32'sd0, 32'sd0, 32'sd0},
        '{32'sd3277 * 6554, 32'sd6554 * 6554, 32'sd3277 * 6554},
        '{32'sd3277 * 7209, 32'sd6554 * 7209, 32'sd3277 * 7209},
        '{32'sd3277 * 5571, 32'sd6554 * 5571, 32'sd3277 * 5571},
        '{32'sd3277 * 6554, 32'sd6554 * 6554, 32'sd3277 * 6554},
        '{32'sd3277 * 3932, 32'sd6554 * 3932, 32'sd3277 * 3932}
    };

    localparam logic [PHASE_BITS-1:0] DUTY_MUS [3] = '{
        PHASE_BITS'(64'd1 << (PHASE_BITS - 1)),
        PHASE_BITS'(64'd1 << (PHASE_BITS - 2)),
        PHASE_BITS'(64'd1 << (PHASE_BITS - 3))
    };

    localparam logic [PHASE_BITS-1:0] DUTY_EFF [5] = '{
        PHASE_BITS'(64'd1 << (PHASE_BITS - 1)),
        PHASE_BITS'(64'd1 << (PHASE_BITS - 1)),
        PHASE_BITS'(64'd1 << (PHASE_BITS - 1)),
        PHASE_BITS'(((64'd1 << PHASE_BITS) * 4 + 5) / 10),
        PHASE_BITS'(((64'd1 << PHASE_BITS) * 9 + 10) / 20)
    };

    localparam logic [LEFT_BITS-1:0] EFF_DUR [5] = '{
        LEFT_BITS'(SAMPLE_RATE / 5), LEFT_BITS'(SAMPLE_RATE / 4),
        LEFT_BITS'(SAMPLE_RATE * 2 / 3), LEFT_BITS'(SAMPLE_RATE / 5),
        LEFT_BITS'(SAMPLE_RATE / 6)
    };

    // per-sample envelope drop, quotient and remainder of 32768 / duration
    localparam logic [ENV_BITS-1:0] ENV_K [5] = '{
        ENV_BITS'(32768 / (SAMPLE_RATE / 5)), ENV_BITS'(32768 / (SAMPLE_RATE / 4)),
        ENV_BITS'(32768 / (SAMPLE_RATE * 2 / 3)), ENV_BITS'(32768 / (SAMPLE_RATE / 5)),
        ENV_BITS'(32768 / (SAMPLE_RATE / 6))
    };
    localparam logic [LEFT_BITS-1:0] ENV_M [5] = '{
        LEFT_BITS'(32768 % (SAMPLE_RATE / 5)), LEFT_BITS'(32768 % (SAMPLE_RATE / 4)),
        LEFT_BITS'(32768 % (SAMPLE_RATE * 2 / 3)), LEFT_BITS'(32768 % (SAMPLE_RATE / 5)),
        LEFT_BITS'(32768 % (SAMPLE_RATE / 6))
    };

    localparam logic [INC_BITS-1:0] EFF_INC_END [5] = '{
        inc_of(104650), inc_of(7000), inc_of(4500), inc_of(78000), inc_of(124000)
    };
    localparam logic signed [INC_BITS:0] EFF_INC_DIFF [5] = '{
        $signed({1'b0, inc_of(104650)}) - $signed({1'b0, inc_of(104650)}),
        $signed({1'b0, inc_of(18000)})  - $signed({1'b0, inc_of(7000)}),
        $signed({1'b0, inc_of(16000)})  - $signed({1'b0, inc_of(4500)}),
        $signed({1'b0, inc_of(32000)})  - $signed({1'b0, inc_of(78000)}),
        $signed({1'b0, inc_of(52000)})  - $signed({1'b0, inc_of(124000)})
    };
    localparam logic [15:0] EFF_GAIN [5] = '{16'd5898, 16'd7864, 16'd9175, 16'd5243, 16'd5571};

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_LOAD = 4'd1;
    localparam logic [3:0] ST_MUS  = 4'd2;
    localparam logic [3:0] ST_EA   = 4'd3;
    localparam logic [3:0] ST_EB   = 4'd4;
    localparam logic [3:0] ST_EC   = 4'd5;
    localparam logic [3:0] ST_ED   = 4'd6;
    localparam logic [3:0] ST_F1   = 4'd7;
    localparam logic [3:0] ST_F2   = 4'd8;

endpackage
`default_nettype wire

// ----- src/sws_front.sv -----
`default_nettype none
module sws_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [7:0]                  in_data,
    output logic                             q_valid,
    input  wire logic                        q_pop,
    output sws_pkg::item_t                   q_item,
    output logic [sws_pkg::QPTR_BITS:0]      q_count
);

    sws_pkg::item_t                  mem_reg [sws_pkg::QDEPTH];
    logic [sws_pkg::QPTR_BITS-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [sws_pkg::QPTR_BITS:0]     cnt_reg, cnt_next;
    sws_pkg::item_t                  cls;
    logic                            push, pop;

    // classify: mode 7 plays the gameplay pattern, long boom swallows boom
    always_comb
    begin
        cls.mode        = in_data[2:0];
        cls.pat         = (in_data[2:0] == sws_pkg::MODE_DEFAULT) ? sws_pkg::PAT_GAMEPLAY
                                                                  : in_data[2:0];
        cls.trig        = {in_data[7], in_data[6], in_data[5],
                           in_data[4] & ~in_data[5], in_data[3]};
        cls.cancel_boom = in_data[5];
    end

    assign in_ready = (cnt_reg != (sws_pkg::QPTR_BITS+1)'(sws_pkg::QDEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;
    assign q_item   = mem_reg[rd_ptr_reg];
    assign q_count  = cnt_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule
`default_nettype wire

// ----- src/sws_back.sv -----
`default_nettype none
module sws_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    output logic                q_pop,
    input  wire sws_pkg::item_t q_item,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [15:0]         out_data,
    output sws_pkg::sts_t       sts
);

    localparam int PB = sws_pkg::PHASE_BITS;
    localparam int SB = sws_pkg::STEP_BITS;

    logic [3:0]                      st_reg, st_next;
    logic [2:0]                      idx_reg, idx_next;
    sws_pkg::item_t                  item_reg;
    logic                            muted_reg;
    logic [PB-1:0]                   mph_reg [3];
    logic [PB-1:0]                   eph_reg [5];
    logic [sws_pkg::LEFT_BITS-1:0]   left_reg [5];
    logic [sws_pkg::ENV_BITS-1:0]    env_reg [5];
    logic [sws_pkg::LEFT_BITS-1:0]   rem_reg [5];
    logic [SB-1:0]                   step_reg;
    logic [sws_pkg::CNT_BITS-1:0]    cnt_reg;
    logic [2:0]                      last_mode_reg;
    logic                            fin_reg;
    logic signed [31:0]              sum_reg;
    logic signed [sws_pkg::PROD_BITS-1:0] prod_reg;
    logic                            sign_reg;
    logic                            out_valid_reg;
    logic [15:0]                     out_data_reg;

    logic signed [31:0]              mul_a;
    logic signed [17:0]              mul_b;
    logic signed [49:0]              mul_p;
    logic [1:0]                      vi;
    logic [sws_pkg::NOTE_BITS-1:0]   note;
    logic [sws_pkg::INC_BITS-1:0]    mus_inc;
    logic [PB-1:0]                   mph_new;
    logic [34:0]                     sweep;
    logic [PB-1:0]                   eff_inc;
    logic [PB-1:0]                   eph_new;
    logic [16:0]                     amp;
    logic signed [sws_pkg::PROD_BITS-1:0] rnd;
    logic signed [sws_pkg::PROD_BITS-31:0] scaled;
    logic [15:0]                     sat;
    logic                            mode_chg, fin_eff;
    logic [sws_pkg::CNT_BITS:0]      cnt_inc;
    logic [SB:0]                     step_inc, len;

    assign vi       = idx_reg[1:0];
    assign mode_chg = (q_item.mode != last_mode_reg);
    assign fin_eff  = mode_chg ? 1'b0 : fin_reg;
    assign q_pop    = (st_reg == sws_pkg::ST_IDLE) && q_valid && !out_valid_reg;
    assign mul_p    = mul_a * mul_b;

    always_comb
    begin
        if (muted_reg)
        begin
            note = '0;
        end
        else if (item_reg.pat == sws_pkg::MODE_BOSS && vi == 2'd0 && step_reg[SB-1:5] != '0)
        begin
            note = '0;
        end
        else
        begin
            note = sws_pkg::PAT_TAB[item_reg.pat][vi][step_reg[3:0]];
        end
        mus_inc = sws_pkg::NOTE_INC[note];
        mph_new = mph_reg[vi] + PB'(mus_inc);
        sweep   = 35'({sws_pkg::EFF_INC_END[idx_reg], 15'd0}) + 35'(prod_reg);
        eff_inc = PB'(sweep[34:15]);
        eph_new = eph_reg[idx_reg] + eff_inc;
        amp     = (idx_reg == 3'd4) ? 17'(17'd13107 + 17'(prod_reg[31:15]))
                                    : 17'(env_reg[idx_reg]);
        rnd     = prod_reg + (prod_reg[sws_pkg::PROD_BITS-1]
                              ? sws_pkg::PROD_BITS'(30'h3fff_ffff) : '0);
        scaled  = rnd[sws_pkg::PROD_BITS-1:30];
        if (scaled > 19'sd32767)
        begin
            sat = 16'h7fff;
        end
        else if (scaled < -19'sd32768)
        begin
            sat = 16'h8000;
        end
        else
        begin
            sat = scaled[15:0];
        end
        cnt_inc  = {1'b0, cnt_reg} + 1'b1;
        step_inc = {1'b0, step_reg} + 1'b1;
        len      = (item_reg.pat == sws_pkg::MODE_BOSS) ? (SB+1)'(sws_pkg::PATTERN_STEPS)
                                                        : (SB+1)'(16);
    end

    // shared multiplier operands
    always_comb
    begin
        case (st_reg)
            sws_pkg::ST_EA:
            begin
                mul_a = 32'(sws_pkg::EFF_INC_DIFF[idx_reg]);
                mul_b = 18'(signed'({1'b0, env_reg[idx_reg]}));
            end
            sws_pkg::ST_EB:
            begin
                mul_a = 32'sd19661;
                mul_b = 18'(signed'({1'b0, env_reg[idx_reg]}));
            end
            sws_pkg::ST_EC:
            begin
                mul_a = 32'(signed'({1'b0, sws_pkg::EFF_GAIN[idx_reg]}));
                mul_b = 18'(signed'({1'b0, amp}));
            end
            default:
            begin
                mul_a = sum_reg;
                mul_b = 18'sd32767;
            end
        endcase
    end

    always_comb
    begin
        st_next  = st_reg;
        idx_next = idx_reg;
        case (st_reg)
            sws_pkg::ST_IDLE:
            begin
                if (q_pop)
                begin
                    st_next = sws_pkg::ST_LOAD;
                end
            end
            sws_pkg::ST_LOAD:
            begin
                st_next  = sws_pkg::ST_MUS;
                idx_next = '0;
            end
            sws_pkg::ST_MUS:
            begin
                if (idx_reg == 3'd2)
                begin
                    st_next  = sws_pkg::ST_EA;
                    idx_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            sws_pkg::ST_EA:
            begin
                if (left_reg[idx_reg] != '0)
                begin
                    st_next = sws_pkg::ST_EB;
                end
                else if (idx_reg == 3'd4)
                begin
                    st_next = sws_pkg::ST_F1;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            sws_pkg::ST_EB: st_next = sws_pkg::ST_EC;
            sws_pkg::ST_EC: st_next = sws_pkg::ST_ED;
            sws_pkg::ST_ED:
            begin
                if (idx_reg == 3'd4)
                begin
                    st_next = sws_pkg::ST_F1;
                end
                else
                begin
                    st_next  = sws_pkg::ST_EA;
                    idx_next = idx_reg + 1'b1;
                end
            end
            sws_pkg::ST_F1: st_next = sws_pkg::ST_F2;
            sws_pkg::ST_F2: st_next = sws_pkg::ST_IDLE;
            default:        st_next = sws_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= sws_pkg::ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            cnt_reg       <= '0;
            last_mode_reg <= '0;
            fin_reg       <= 1'b0;
            muted_reg     <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                mph_reg[i] <= '0;
            end
            for (int i = 0; i < 5; i++)
            begin
                eph_reg[i]  <= '0;
                left_reg[i] <= '0;
                env_reg[i]  <= '0;
                rem_reg[i]  <= '0;
            end
        end
        else
        begin
            st_reg  <= st_next;
            idx_reg <= idx_next;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (st_reg)
                sws_pkg::ST_IDLE:
                begin
                    if (q_pop)
                    begin
                        // triggers and mode change land before this tick's sample
                        for (int e = 0; e < 5; e++)
                        begin
                            if (q_item.trig[e])
                            begin
                                left_reg[e] <= sws_pkg::EFF_DUR[e];
                                env_reg[e]  <= sws_pkg::ENV_ONE;
                                rem_reg[e]  <= '0;
                                eph_reg[e]  <= '0;
                            end
                        end
                        if (q_item.cancel_boom)
                        begin
                            left_reg[1] <= '0;
                            env_reg[1]  <= '0;
                            rem_reg[1]  <= '0;
                        end
                        if (mode_chg)
                        begin
                            last_mode_reg <= q_item.mode;
                            step_reg      <= '0;
                            cnt_reg       <= '0;
                            fin_reg       <= 1'b0;
                            for (int i = 0; i < 3; i++)
                            begin
                                mph_reg[i] <= '0;
                            end
                        end
                        muted_reg <= (q_item.mode == sws_pkg::MODE_GAMEOVER) && fin_eff;
                    end
                end
                sws_pkg::ST_MUS:
                begin
                    if (mus_inc != '0)
                    begin
                        mph_reg[vi] <= mph_new;
                    end
                end
                sws_pkg::ST_EB:
                begin
                    if (eff_inc != '0)
                    begin
                        eph_reg[idx_reg] <= eph_new;
                    end
                end
                sws_pkg::ST_ED:
                begin
                    // envelope tracks floor(left * 32768 / duration) step by step
                    left_reg[idx_reg] <= left_reg[idx_reg] - 1'b1;
                    if (rem_reg[idx_reg] < sws_pkg::ENV_M[idx_reg])
                    begin
                        rem_reg[idx_reg] <= rem_reg[idx_reg] - sws_pkg::ENV_M[idx_reg]
                                            + sws_pkg::EFF_DUR[idx_reg];
                        env_reg[idx_reg] <= env_reg[idx_reg] - sws_pkg::ENV_K[idx_reg] - 1'b1;
                    end
                    else
                    begin
                        rem_reg[idx_reg] <= rem_reg[idx_reg] - sws_pkg::ENV_M[idx_reg];
                        env_reg[idx_reg] <= env_reg[idx_reg] - sws_pkg::ENV_K[idx_reg];
                    end
                end
                sws_pkg::ST_F2:
                begin
                    out_valid_reg <= 1'b1;
                    if (cnt_inc >= {1'b0, sws_pkg::SPS[item_reg.pat]})
                    begin
                        cnt_reg <= '0;
                        if (!muted_reg)
                        begin
                            if (step_inc >= len)
                            begin
                                if (item_reg.mode == sws_pkg::MODE_GAMEOVER)
                                begin
                                    step_reg <= SB'(len - 1'b1);
                                    fin_reg  <= 1'b1;
                                end
                                else
                                begin
                                    step_reg <= '0;
                                end
                            end
                            else
                            begin
                                step_reg <= step_inc[SB-1:0];
                            end
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_inc[sws_pkg::CNT_BITS-1:0];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p[sws_pkg::PROD_BITS-1:0];
        case (st_reg)
            sws_pkg::ST_IDLE:
            begin
                if (q_pop)
                begin
                    item_reg <= q_item;
                end
            end
            sws_pkg::ST_LOAD:
            begin
                sum_reg <= '0;
            end
            sws_pkg::ST_MUS:
            begin
                if (mus_inc != '0)
                begin
                    if (mph_new < sws_pkg::DUTY_MUS[vi])
                    begin
                        sum_reg <= sum_reg + sws_pkg::MUS_WG[item_reg.pat][vi];
                    end
                    else
                    begin
                        sum_reg <= sum_reg - sws_pkg::MUS_WG[item_reg.pat][vi];
                    end
                end
            end
            sws_pkg::ST_EB:
            begin
                sign_reg <= (eff_inc != '0) && !(eph_new < sws_pkg::DUTY_EFF[idx_reg]);
            end
            sws_pkg::ST_ED:
            begin
                if (sign_reg)
                begin
                    sum_reg <= sum_reg - prod_reg[31:0];
                end
                else
                begin
                    sum_reg <= sum_reg + prod_reg[31:0];
                end
            end
            sws_pkg::ST_F2:
            begin
                out_data_reg <= sat;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign sts.busy  = (st_reg != sws_pkg::ST_IDLE);
    assign sts.st    = st_reg;

endmodule
`default_nettype wire

// ----- src/square_wave_sound_synth.sv -----
// Square-wave chiptune synthesizer, one input transfer per audio sample tick.
// s_axis carries the music mode and five one-shot effect triggers; m_axis
// returns one signed 16-bit mixed sample per input transfer, in order.
// Input transfers go into a four-entry queue; the sample engine takes the
// queue head once its output register is empty, then runs three music
// voices in ST_MUS, up to five active effects (states EA, EB, EC and ED
// each, all sharing one 32x18 multiplier) and a final scale and saturate
// in F1 and F2. It takes no new queue item until the last sample has left
// the output register.
// Reset clears all phases, effects, the sequencer and the queue; mode
// starts as mode 0. A stall on m_axis holds the sample in the output register;
// the queue keeps taking input transfers until it holds four.
`default_nettype none
module square_wave_sound_synth (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [2:0] music_mode, [3] trig_ding, [4] trig_boom, [5] trig_boom_long,
    // [6] trig_laser, [7] trig_powerup
    input  wire logic [7:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [15:0] audio_sample
    output logic [15:0]      m_axis_tdata
);

    logic                           q_valid, q_pop;
    sws_pkg::item_t                 q_item;
    logic [sws_pkg::QPTR_BITS:0]    q_count;
    sws_pkg::sts_t                  sts;

    sws_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item),
        .q_count  (q_count)
    );

    sws_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .sts       (sts)
    );

    a_out_from_final: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(sts.st == sws_pkg::ST_F2))
        else $error("sample presented outside final engine step");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= (sws_pkg::QPTR_BITS+1)'(sws_pkg::QDEPTH))
        else $error("input queue overrun");

    a_busy_empty_out: assert property (@(posedge clk) disable iff (!rst_n)
        sts.busy |-> !m_axis_tvalid)
        else $error("engine running while output register full");

endmodule
`default_nettype wire

// ----- tb/sv/square_wave_sound_synth_tb.sv -----
`timescale 1ns / 100ps
module square_wave_sound_synth_tb;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int N_ITEMS     = 1850;
    localparam int PB          = sws_pkg::PHASE_BITS;

    localparam int unsigned ROM16 [7][3][16] = '{
        '{ '{16{0}}, '{16{0}}, '{16{0}} },
        '{ '{16{0}}, '{16{0}}, '{16{0}} },
        '{ '{16{0}},
           '{13081,0,0,0,17461,0,0,0,14683,0,0,0,13081,0,0,0},
           '{16{0}} },
        '{ '{16{0}}, '{16{0}}, '{16{0}} },
        '{ '{16{0}},
           '{16481,0,19600,0,22000,0,19600,0,16481,0,19600,0,22000,0,19600,0},
           '{16{0}} },
        '{ '{65925,62225,58733,52325,49388,44000,39200,34923,32963,0,0,0,0,0,0,0},
           '{16481,0,14683,0,13081,0,12347,0,11000,0,0,0,0,0,0,0},
           '{32963,0,29366,0,26163,0,24694,0,22000,0,0,0,0,0,0,0} },
        '{ '{52325,0,0,0,52325,0,0,0,65925,0,0,0,65925,0,0,0},
           '{13081,0,0,0,13081,0,0,0,14683,0,0,0,14683,0,0,0},
           '{16{0}} }
    };
    localparam int unsigned BOSS_MEL [16] =
        '{34923,0,34923,41530,46616,0,46616,52325,34923,0,34923,41530,0,0,0,0};
    localparam int unsigned BOSS_BASS [16] =
        '{8731,8731,0,8731,9250,9250,0,9250,7778,7778,0,7778,8731,8731,9250,0};
    localparam int unsigned BOSS_HARM [8] = '{17461,0,23308,0,26163,0,31113,0};
    localparam int unsigned BPM [7]     = '{118, 120, 142, 128, 124, 88, 60};
    localparam longint      PGAIN [7]   = '{5898, 0, 6554, 7209, 5571, 6554, 3932};
    localparam longint      VWEIGHT [3] = '{3277, 6554, 3277};
    localparam int unsigned FX_START [5] = '{104650, 18000, 16000, 32000, 52000};
    localparam int unsigned FX_END [5]   = '{104650, 7000, 4500, 78000, 124000};
    localparam longint      FX_GAIN [5]  = '{5898, 7864, 9175, 5243, 5571};
    localparam int unsigned FX_LEN [5]   = '{8820, 11025, 29400, 8820, 7350};

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    int  errors;
    int  cycles;
    bit  calm;

    square_wave_sound_synth u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    task automatic report_mismatch(input string what);
        $display("mismatch @%0t: %s", $time, what);
        errors++;
    endtask

    class synth_scoreboard;
        logic [PB-1:0]         phase [8];
        int unsigned           fx_left [5];
        int unsigned           step;
        int unsigned           step_cnt;
        logic [2:0]            prev_mode;
        bit                    finished;
        logic [15:0]           samples_due [$];

        function longint unsigned phase_inc(input longint unsigned centi_hz);
            return ((centi_hz << PB) + 64'd2205000) / 64'd4410000;
        endfunction

        function longint unsigned duty(input int code);
            longint unsigned one;
            one = 64'd1 << PB;
            case (code)
                0: return one >> 1;
                1: return one >> 2;
                2: return one >> 3;
                3: return (one * 4 + 5) / 10;
                default: return (one * 9 + 10) / 20;
            endcase
        endfunction

        function longint square(input int v, input longint unsigned inc, input int code);
            if (inc == 0)
                return 0;
            phase[v] = phase[v] + inc[PB-1:0];
            return (phase[v] < duty(code)) ? 1 : -1;
        endfunction

        function int unsigned note_freq(input int pat, input int v, input int unsigned s);
            if (pat == sws_pkg::MODE_BOSS)
            begin
                if (v == 0)
                    return (s < 32) ? BOSS_MEL[s % 16] : 0;
                if (v == 1)
                    return BOSS_BASS[s % 16];
                return BOSS_HARM[s % 8];
            end
            return ROM16[pat][v][s % 16];
        endfunction

        function void reset_state();
            foreach (phase[i])
                phase[i] = '0;
            foreach (fx_left[i])
                fx_left[i] = 0;
            step = 0;
            step_cnt = 0;
            prev_mode = '0;
            finished = 0;
        endfunction

        function void note_tick(input logic [7:0] d);
            logic [2:0]       mode;
            int               pat;
            int unsigned      steps;
            int unsigned      sps;
            bit               muted;
            longint           sum;
            longint           smp;
            longint unsigned  env;
            longint unsigned  inc;
            longint unsigned  amp;
            mode = d[2:0];
            for (int e = 0; e < 5; e++)
            begin
                if (d[3+e])
                begin
                    fx_left[e] = FX_LEN[e];
                    phase[3+e] = '0;
                    if (e == 2)
                        fx_left[1] = 0;
                end
            end
            if (mode != prev_mode)
            begin
                prev_mode = mode;
                step = 0;
                step_cnt = 0;
                finished = 0;
                for (int v = 0; v < 3; v++)
                    phase[v] = '0;
            end
            pat = (mode == sws_pkg::MODE_DEFAULT) ? sws_pkg::PAT_GAMEPLAY : mode;
            steps = (pat == sws_pkg::MODE_BOSS) ? sws_pkg::PATTERN_STEPS : 16;
            sps = (sws_pkg::SAMPLE_RATE * 60) / (BPM[pat] * 4);
            muted = (mode == sws_pkg::MODE_GAMEOVER) && finished;
            sum = 0;
            for (int v = 0; v < 3; v++)
            begin
                inc = phase_inc(muted ? 0 : note_freq(pat, v, step));
                sum += square(v, inc, v) * VWEIGHT[v] * PGAIN[pat];
            end
            for (int e = 0; e < 5; e++)
            begin
                if (fx_left[e] > 0)
                begin
                    env = (longint'(fx_left[e]) << 15) / FX_LEN[e];
                    if (env > 32768)
                        env = 32768;
                    inc = (phase_inc(FX_START[e]) * env
                           + phase_inc(FX_END[e]) * (32768 - env)) >> 15;
                    amp = (e == 4) ? 13107 + ((19661 * env) >> 15) : env;
                    sum += square(3 + e, inc, (e == 3) ? 3 : ((e == 4) ? 4 : 0))
                           * FX_GAIN[e] * longint'(amp);
                    fx_left[e]--;
                end
            end
            smp = (sum * 32767) / 64'sd1073741824;
            if (smp > 32767)
                smp = 32767;
            if (smp < -32768)
                smp = -32768;
            samples_due.push_back(smp[15:0]);
            step_cnt++;
            if (step_cnt >= sps)
            begin
                step_cnt = 0;
                if (!muted)
                begin
                    step++;
                    if (step >= steps)
                    begin
                        if (mode == sws_pkg::MODE_GAMEOVER)
                        begin
                            step = steps - 1;
                            finished = 1;
                        end
                        else
                            step = 0;
                    end
                end
            end
        endfunction

        task check_sample(input logic [15:0] got);
            logic [15:0] want;
            if (samples_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected sample %0d", $signed(got)));
                return;
            end
            want = samples_due.pop_front();
            if (got !== want)
                report_mismatch($sformatf("audio_sample got %0d want %0d",
                                          $signed(got), $signed(want)));
        endtask

        function int pending();
            return samples_due.size();
        endfunction
    endclass

    synth_scoreboard sb;

    function automatic bit idle_now();
        return !calm && ($urandom_range(0, 99) < 29);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: ready toggles at the falling edge, transfers checked at the rising edge
    always @(negedge clk)
        if (rst_n)
            m_axis_tready = !idle_now();

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_sample(m_axis_tdata);

    task automatic send_tick(input logic [2:0] mode, input logic [4:0] trig);
        @(negedge clk);
        while (idle_now())
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {trig, mode};
        forever
        begin
            @(posedge clk);
            if (s_axis_tready)
                break;
        end
        sb.note_tick(s_axis_tdata);
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [4:0] rand_trig(input int pct);
        logic [4:0] t;
        for (int i = 0; i < 5; i++)
            t[i] = ($urandom_range(0, 999) < pct);
        return t;
    endfunction

    initial
    begin
        int         sent;
        int         run;
        logic [2:0] mode;
        sb = new();
        sb.reset_state();
        errors = 0;
        cycles = 0;
        calm = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: every mode, each effect alone, boom with long boom, all at once
        for (int m = 0; m < 8; m++)
            send_tick(m[2:0], 5'b0);
        for (int e = 0; e < 5; e++)
            send_tick(3'd2, 5'b1 << e);
        send_tick(3'd3, 5'b00110);
        send_tick(3'd3, 5'b11111);
        send_tick(3'd5, 5'b11111);
        send_tick(3'd5, 5'b0);
        send_tick(3'd7, 5'b00010);
        send_tick(3'd7, 5'b00010);
        drain();

        sent = 0;
        while (sent < N_ITEMS)
        begin
            mode = 3'($urandom_range(0, 7));
            run = int'($urandom_range(5, 150));
            for (int k = 0; k < run && sent < N_ITEMS; k++)
            begin
                calm = (sent >= 600 && sent < 900);
                send_tick(mode, rand_trig(($urandom_range(0, 9) == 0) ? 300 : 15));
                sent++;
                if (sent == 1200)
                    drain();
            end
        end
        calm = 0;
        drain();
        repeat (40) @(posedge clk);
        if (sb.pending() != 0)
            report_mismatch($sformatf("%0d samples never arrived", sb.pending()));
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ----- files.f -----
src/sws_pkg.sv
src/sws_front.sv
src/sws_back.sv
src/square_wave_sound_synth.sv
tb/sv/square_wave_sound_synth_tb.sv
